@@ rtl/leb_pkg.sv @@
package leb_pkg;

  // Default buffer size in characters.
  localparam int CAPACITY_DEF = 64;

  // Field widths of the input and result transactions.
  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 8;
  localparam int PEEK_W   = 6;
  localparam int POS_W    = 7;

  // Lowest character code that insert accepts.
  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;

  // Key action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_BACKSPACE = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_LEFT      = 3'd3,
    ACT_RIGHT     = 3'd4,
    ACT_HOME      = 3'd5,
    ACT_END       = 3'd6,
    ACT_REDRAW    = 3'd7
  } action_t;

endpackage

@@ rtl/line_edit_buffer.sv @@
// The result strobe is high in the response state after the peek read. A cursor move, redraw
// or refused action goes to the peek read directly; an edit that moves characters first passes
// the shift and flush states, and an insert also writes the new character. Throughput: one
// transaction at a time; busy stays high until the result cycle ends, and the character memory
// (one write port, one registered read port) moves one character per cycle. A synchronous
// reset clears length and cursor; the character memory is not cleared.
module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [PEEK_W-1:0]   in_peek_index,
  output logic                out_strobe,
  output logic                out_changed,
  output logic [POS_W-1:0]    out_text_len,
  output logic [POS_W-1:0]    out_cursor,
  output logic [CHAR_W-1:0]   out_peek_char
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > PEEK_W) ? LW : PEEK_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
  localparam logic [LW-1:0] ONE_L = LW'(1);
  localparam logic [AW-1:0] ONE_A = AW'(1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SHIFT = 6'b000010,
    ST_FLUSH = 6'b000100,
    ST_INS   = 6'b001000,
    ST_PEEK  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic              changed_r, changed_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic [AW-1:0]     ins_addr_r, ins_addr_nxt;
  logic              up_r, up_nxt;
  logic              ins_r, ins_nxt;
  logic              pend_r, pend_nxt;
  logic [CHAR_W-1:0] code_r;
  logic [PEEK_W-1:0] peek_r;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic              accept;
  logic              peek_hit;

  assign accept = start && (state_r == ST_IDLE);

  // Sequencer: decides the edit at acceptance, then moves characters one per cycle.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    cur_nxt      = cur_r;
    changed_nxt  = changed_r;
    ptr_nxt      = ptr_r;
    end_nxt      = end_r;
    dst_nxt      = dst_r;
    ins_addr_nxt = ins_addr_r;
    up_nxt       = up_r;
    ins_nxt      = ins_r;
    pend_nxt     = pend_r;
    mem_we       = 1'b0;
    mem_waddr    = dst_r;
    mem_wdata    = rdata_r;
    mem_raddr    = ptr_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          changed_nxt = 1'b0;
          ins_nxt     = 1'b0;
          pend_nxt    = 1'b0;
          state_nxt   = ST_PEEK;
          case (action_t'(in_action))
            ACT_INSERT: begin
              if (in_char_code >= FIRST_PRINTABLE && len_r < CAP_L) begin
                changed_nxt  = 1'b1;
                len_nxt      = len_r + ONE_L;
                cur_nxt      = cur_r + ONE_L;
                ins_addr_nxt = AW'(cur_r);
                ins_nxt      = 1'b1;
                up_nxt       = 1'b1;
                if (len_r > cur_r) begin
                  ptr_nxt   = AW'(len_r - ONE_L);
                  end_nxt   = AW'(cur_r);
                  state_nxt = ST_SHIFT;
                end else begin
                  state_nxt = ST_INS;
                end
              end
            end
            ACT_BACKSPACE: begin
              if (len_r != '0 && cur_r != '0) begin
                changed_nxt = 1'b1;
                len_nxt     = len_r - ONE_L;
                cur_nxt     = cur_r - ONE_L;
                up_nxt      = 1'b0;
                if (cur_r < len_r) begin
                  ptr_nxt   = AW'(cur_r);
                  end_nxt   = AW'(len_r - ONE_L);
                  state_nxt = ST_SHIFT;
                end
              end
            end
            ACT_DELETE: begin
              if (len_r != '0 && cur_r != len_r) begin
                changed_nxt = 1'b1;
                len_nxt     = len_r - ONE_L;
                up_nxt      = 1'b0;
                if (cur_r + ONE_L < len_r) begin
                  ptr_nxt   = AW'(cur_r + ONE_L);
                  end_nxt   = AW'(len_r - ONE_L);
                  state_nxt = ST_SHIFT;
                end
              end
            end
            ACT_LEFT: begin
              if (cur_r != '0) begin
                changed_nxt = 1'b1;
                cur_nxt     = cur_r - ONE_L;
              end
            end
            ACT_RIGHT: begin
              if (cur_r != len_r) begin
                changed_nxt = 1'b1;
                cur_nxt     = cur_r + ONE_L;
              end
            end
            ACT_HOME: begin
              if (cur_r != '0) begin
                changed_nxt = 1'b1;
                cur_nxt     = '0;
              end
            end
            ACT_END: begin
              if (cur_r != len_r) begin
                changed_nxt = 1'b1;
                cur_nxt     = len_r;
              end
            end
            default: begin
              changed_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // Read the next source while the previous one is written to its new place.
        mem_raddr = ptr_r;
        mem_we    = pend_r;
        pend_nxt  = 1'b1;
        dst_nxt   = up_r ? ptr_r + ONE_A : ptr_r - ONE_A;
        if (ptr_r == end_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          ptr_nxt = up_r ? ptr_r - ONE_A : ptr_r + ONE_A;
        end
      end
      ST_FLUSH: begin
        mem_we    = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = ins_r ? ST_INS : ST_PEEK;
      end
      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = ins_addr_r;
        mem_wdata = code_r;
        state_nxt = ST_PEEK;
      end
      ST_PEEK: begin
        mem_raddr = AW'(peek_r);
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      cur_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    changed_r  <= changed_nxt;
    ptr_r      <= ptr_nxt;
    end_r      <= end_nxt;
    dst_r      <= dst_nxt;
    ins_addr_r <= ins_addr_nxt;
    up_r       <= up_nxt;
    ins_r      <= ins_nxt;
    if (accept) begin
      code_r <= in_char_code;
      peek_r <= in_peek_index;
    end
  end

  // Character memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Result transaction.
  assign peek_hit      = CW'(peek_r) < CW'(len_r);
  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = (state_r == ST_RESP);
  assign out_changed   = changed_r;
  assign out_text_len  = POS_W'(len_r);
  assign out_cursor    = POS_W'(cur_r);
  assign out_peek_char = peek_hit ? rdata_r : '0;

  // The block goes busy once a transaction is taken.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // A result strobe lasts a single cycle and is followed by idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |=> (!out_strobe && !busy))
    else $error("result strobe longer than one cycle");

  // The cursor never passes the end of the text, and the text never exceeds the buffer.
  assert property (@(posedge clk) disable iff (!rst_n) (cur_r <= len_r) && (len_r <= CAP_L))
    else $error("cursor or length out of range");

  // The memory is written only while characters are being moved or inserted.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SHIFT || state_r == ST_FLUSH || state_r == ST_INS))
    else $error("memory write outside an edit");

endmodule
